FILE: hdl/signed_int_to_decimal_ascii_core_defines.svh
// Assertion macros shared by the RTL that checks itself.
// Both macros sample on the rising edge of clk and are idle while arst_n is low.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITOA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

	localparam int MAG_W      = 32;
	localparam int NUM_DIGITS = 10;
	localparam int STEP_W     = $clog2(MAG_W);
	localparam int CNT_W      = $clog2(NUM_DIGITS + 1);

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAG_W - 1);

	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;

	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

	typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic next;
		logic prep;
	} itoa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic conv_done;
		logic last;
	} itoa_sts_t;

endpackage

`default_nettype wire

FILE: hdl/itoa_dp.sv
`default_nettype none

module itoa_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [31:0]       value,
	input  wire itoa_pkg::itoa_cmd_t cmd,
	output itoa_pkg::itoa_sts_t    sts,
	output logic [7:0]             ascii_char,
	output logic                   last_char
);

	import itoa_pkg::*;

	logic [MAG_W-1:0]  bin_q;
	bcd_t              bcd_q;
	bcd_t              bcd_adj;
	logic [4*NUM_DIGITS-1:0] bcd_flat;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  dcnt_q;
	logic [CNT_W-1:0]  ndig;
	logic [CNT_W-1:0]  cnt_src;
	logic [CNT_W-1:0]  dig_idx;
	logic [7:0]        char_q;
	logic              last_q;

	// Add-3 correction on every digit before the shift.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= BCD_ADJ_MIN) ? bcd_q[i] + BCD_ADJ_ADD : bcd_q[i];
		end
	end

	assign bcd_flat = bcd_adj;

	// Number of significant digits; zero still shows one digit.
	always_comb begin
		ndig = CNT_W'(1);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i] != 4'd0) begin
				ndig = CNT_W'(i + 1);
			end
		end
	end

	assign cnt_src = cmd.prep ? ndig : dcnt_q;
	assign dig_idx = cnt_src - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.load) begin
			step_q <= '0;
		end else if (cmd.step) begin
			step_q <= step_q + STEP_W'(1);
		end else if (cmd.next) begin
			dcnt_q <= neg_q ? cnt_src : dig_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[MAG_W-1];
			bin_q <= value[MAG_W-1] ? (MAG_W'(0) - value) : value;
			bcd_q <= '0;
		end else if (cmd.step) begin
			bcd_q <= {bcd_flat[4*NUM_DIGITS-2:0], bin_q[MAG_W-1]};
			bin_q <= {bin_q[MAG_W-2:0], 1'b0};
		end else if (cmd.next) begin
			if (neg_q) begin
				char_q <= CH_MINUS;
				last_q <= 1'b0;
				neg_q  <= 1'b0;
			end else begin
				char_q <= CH_ZERO + {4'd0, bcd_q[dig_idx]};
				last_q <= (cnt_src == CNT_W'(1));
			end
		end
	end

	assign sts.conv_done = (step_q == STEP_LAST);
	assign sts.last      = last_q;
	assign ascii_char    = char_q;
	assign last_char     = last_q;

endmodule

`default_nettype wire

FILE: hdl/itoa_ctrl.sv
`default_nettype none

module itoa_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire itoa_pkg::itoa_sts_t sts,
	output itoa_pkg::itoa_cmd_t  cmd
);

	import itoa_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_PREP = 4'b0100,
		ST_SHOW = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SHOW);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.step = 1'b1;
				if (sts.conv_done) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				// Loads the first character straight from the digit count.
				cmd.next = 1'b1;
				cmd.prep = 1'b1;
				state_d  = ST_SHOW;
			end
			ST_SHOW: begin
				if (out_ready) begin
					if (sts.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/signed_int_to_decimal_ascii_core.sv
// Channel  Handshake             Payload
// input    in_valid / in_ready   value[31:0] (signed)
// output   out_valid / out_ready ascii_char[7:0], last_char
//
// One value is converted at a time. After the input transfer, a shift-and-add-3
// loop runs over the 32 magnitude bits, then the prep state forms the first character.
// Characters follow at one per cycle while out_ready is high: 1 to 11 per value.
// A stalled output holds the current character; in_ready is high only when idle.
// Reset returns the controller to idle; no stored state survives a value.
`default_nettype none

`include "signed_int_to_decimal_ascii_core_defines.svh"

module signed_int_to_decimal_ascii_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       ascii_char,
	output logic             last_char
);

	import itoa_pkg::*;

	itoa_cmd_t cmd;
	itoa_sts_t sts;

	itoa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	itoa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.ascii_char (ascii_char),
		.last_char  (last_char)
	);

	`ITOA_ASSERT_NOW(a_ready_excl, in_ready, !out_valid, "input ready while showing")
	`ITOA_ASSERT_NEXT(a_in_then_busy, in_valid && in_ready, !out_valid && !in_ready, "no busy time")
	`ITOA_ASSERT_NEXT(a_more_chars, out_valid && out_ready && !last_char, out_valid, "text cut")
	`ITOA_ASSERT_NEXT(a_last_idle, out_valid && out_ready && last_char, in_ready, "not idle")

endmodule

`default_nettype wire
